FILE: sv/rrpsp_pkg.sv
// Shared constants, types and codes for the round-robin pending signal picker.
// Used by every module and interface of the block; depends on nothing.
package rrpsp_pkg;

    // Slot array geometry.
    localparam int SIGNAL_SLOTS = 32;
    localparam int FIRST_SIGNAL = 1;
    localparam int COUNT_BITS   = 16;
    localparam int SLOT_BITS    = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;

    // Fixed field widths of the request and response.
    localparam int OPCODE_W = 1;
    localparam int SIGNUM_W = 5;
    localparam int CODE_W   = 5;
    localparam int SIGCNT_W = 16;
    localparam int TOTAL_W  = 32;

    // Compare width wide enough for both a signal number and the slot count.
    localparam int CMP_W = ((SLOT_BITS > SIGNUM_W) ? SLOT_BITS : SIGNUM_W) + 1;

    typedef logic [SLOT_BITS-1:0]    t_slot;
    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [SIGNAL_SLOTS-1:0] t_slot_vec;

    localparam t_count COUNT_MAX = '1;

    // Request operation codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ARRIVE = 1'b0,
        OP_CHOOSE = 1'b1
    } t_op;

    // Control sequencer states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Result of the rotating find-first.
    typedef struct packed {
        logic  found;
        t_slot idx;
    } t_pick;

endpackage

FILE: sv/rrpsp_if.sv
// Request and response channel interfaces of the pending signal picker.
// Depends on rrpsp_pkg for field widths.
interface rrpsp_req_if import rrpsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SIGNUM_W-1:0] signal_number;

    modport source (output valid, opcode, signal_number, input ready);
    modport sink   (input valid, opcode, signal_number, output ready);
endinterface

interface rrpsp_rsp_if import rrpsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   signal_code;
    logic [SIGCNT_W-1:0] signal_count;
    logic                none_pending;
    logic [TOTAL_W-1:0]  total_handled;

    modport source (output valid, signal_code, signal_count, none_pending, total_handled,
                    input ready);
    modport sink   (input valid, signal_code, signal_count, none_pending, total_handled,
                    output ready);
endinterface

FILE: sv/rrpsp_count_mem.sv
// Pending count memory: one write port and one read port, registered read data.
// Depends on rrpsp_pkg for the slot and count types.
module rrpsp_count_mem
    import rrpsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rd_en,
    input  t_slot  i_rd_addr,
    output t_count o_rd_data,
    input  logic   i_wr_en,
    input  t_slot  i_wr_addr,
    input  t_count i_wr_data
);

    t_count r_mem [SIGNAL_SLOTS];
    t_count r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/rrpsp_pick.sv
// Rotating find-first over the pending flags, starting after the scan pointer.
// Depends on rrpsp_pkg for the slot vector and pick result types.
module rrpsp_pick
    import rrpsp_pkg::*;
(
    input  t_slot_vec i_pending,
    input  t_slot     i_ptr,
    output t_pick     o_pick
);

    always_comb begin
        t_slot_vec upper;
        logic      hi_found;
        t_slot     hi_idx;
        logic      lo_found;
        t_slot     lo_idx;

        // Flags strictly above the pointer are searched first.
        for (int i = 0; i < SIGNAL_SLOTS; i++) begin
            upper[i] = i_pending[i] && (t_slot'(i) > i_ptr);
        end

        hi_found = |upper;
        lo_found = |i_pending;
        hi_idx   = '0;
        lo_idx   = '0;

        // Descending loops leave the lowest set index.
        for (int i = SIGNAL_SLOTS - 1; i >= 0; i--) begin
            if (upper[i]) begin
                hi_idx = t_slot'(i);
            end
            if (i_pending[i]) begin
                lo_idx = t_slot'(i);
            end
        end

        // Otherwise wrap to the lowest pending slot.
        o_pick.found = lo_found;
        o_pick.idx   = hi_found ? hi_idx : lo_idx;
    end

endmodule

FILE: sv/round_robin_pending_signal_picker.sv
// Round-robin pending signal picker, top level.
// Each request is accepted with its count read in S_IDLE, then updated in S_EXEC; a new request
// is taken only in S_IDLE, and a choose waits in S_EXEC while the last response is not taken.
// A choose response is registered and appears the cycle after the update cycle; an arrival gives
// no response. Synchronous active-low reset clears the pending flags, scan pointer and total;
// flagged-off slots read as zero, so there is no memory clearing pass.
module round_robin_pending_signal_picker
    import rrpsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrpsp_req_if.sink   i_req,
    rrpsp_rsp_if.source o_rsp
);

    // Control state.
    t_state    r_state, n_state;
    t_slot_vec r_pending, n_pending;
    t_slot     r_ptr, n_ptr;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic      r_out_valid, n_out_valid;

    // Request held across the update cycle.
    t_op       r_op;
    t_slot     r_slot;
    logic      r_arg_ok;

    // Response payload registers.
    logic [CODE_W-1:0]   r_code, n_code;
    logic [SIGCNT_W-1:0] r_cnt, n_cnt;
    logic                r_none, n_none;
    logic [TOTAL_W-1:0]  r_tot_out, n_tot_out;

    logic   req_accept;
    t_pick  pick;
    t_slot  sig_slot;
    logic   sig_ok;
    t_slot  rd_addr;
    t_count rd_data;
    t_count cur_cnt;
    logic   wr_en;
    t_count wr_data;

    // Arrival slot and range check.
    assign sig_slot = t_slot'(i_req.signal_number);
    assign sig_ok   = (CMP_W'(i_req.signal_number) >= CMP_W'(FIRST_SIGNAL)) &&
                      (CMP_W'(i_req.signal_number) <  CMP_W'(SIGNAL_SLOTS));

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;

    rrpsp_pick u_pick (
        .i_pending (r_pending),
        .i_ptr     (r_ptr),
        .o_pick    (pick)
    );

    assign rd_addr = (t_op'(i_req.opcode) == OP_CHOOSE) ? pick.idx : sig_slot;

    rrpsp_count_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (req_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (wr_data)
    );

    // A slot without its pending flag holds a zero count.
    assign cur_cnt = r_pending[r_slot] ? rd_data : '0;

    // Capture the request on acceptance.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_op <= t_op'(i_req.opcode);
            if (t_op'(i_req.opcode) == OP_CHOOSE) begin
                r_slot   <= pick.idx;
                r_arg_ok <= pick.found;
            end else begin
                r_slot   <= sig_slot;
                r_arg_ok <= sig_ok;
            end
        end
    end

    // Next state, memory write and response load.
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_ptr       = r_ptr;
        n_total     = r_total;
        n_out_valid = (r_out_valid && o_rsp.ready) ? 1'b0 : r_out_valid;
        n_code      = r_code;
        n_cnt       = r_cnt;
        n_none      = r_none;
        n_tot_out   = r_tot_out;
        wr_en       = 1'b0;
        wr_data     = cur_cnt + COUNT_BITS'(1);

        case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_ARRIVE) begin
                    // Saturating increment of the arriving slot.
                    if (r_arg_ok && (cur_cnt != COUNT_MAX)) begin
                        wr_en             = 1'b1;
                        n_pending[r_slot] = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_rsp.ready) begin
                    // Choose: hand out the slot and clear it, or report that none is pending.
                    n_out_valid = 1'b1;
                    if (r_arg_ok) begin
                        n_pending[r_slot] = 1'b0;
                        n_ptr             = r_slot;
                        n_total           = r_total + TOTAL_W'(cur_cnt);
                        n_code            = CODE_W'(r_slot);
                        n_cnt             = SIGCNT_W'(32'(cur_cnt));
                        n_none            = 1'b0;
                        n_tot_out         = r_total + TOTAL_W'(cur_cnt);
                    end else begin
                        n_code    = '0;
                        n_cnt     = '0;
                        n_none    = 1'b1;
                        n_tot_out = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= '0;
            r_ptr       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_ptr       <= n_ptr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_cnt     <= n_cnt;
        r_none    <= n_none;
        r_tot_out <= n_tot_out;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.signal_code   = r_code;
    assign o_rsp.signal_count  = r_cnt;
    assign o_rsp.none_pending  = r_none;
    assign o_rsp.total_handled = r_tot_out;

endmodule

FILE: bench/round_robin_pending_signal_picker_test.sv
// Self-checking bench for the round-robin pending signal picker:
// a directed table, then random traffic.
// Depends on rrpsp_pkg, the request and response interfaces and the picker top level.
module round_robin_pending_signal_picker_test;
    import rrpsp_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPEAT_REPS   = 3;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 10;

    // One response of the picker, in port order.
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [SIGCNT_W-1:0] count;
        logic                none;
        logic [TOTAL_W-1:0]  total;
    } t_pick_result;

    // One row of the directed table; a typed row carries its response.
    typedef struct {
        t_op                 op;
        logic [SIGNUM_W-1:0] num;
        int                  reps;
        bit                  typed;
        t_pick_result        want;
    } t_stim_row;

    localparam t_pick_result NO_WANT     = '0;
    localparam t_pick_result NONE_PICKED = '{5'd0, 16'd0, 1'b1, 32'd0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrpsp_req_if req_ch ();
    rrpsp_rsp_if rsp_ch ();

    round_robin_pending_signal_picker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Free-running clock, period 4.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted picker state.
    t_count             pend_cnt [SIGNAL_SLOTS];
    t_slot              scan_ptr;
    logic [TOTAL_W-1:0] handled_sum;

    t_pick_result expected_picks [$];
    int  mismatch_count = 0;
    int  picks_checked  = 0;
    int  empty_picks    = 0;
    int  requests_sent  = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  tail_calm      = 1'b0;

    // Directed table: empty picks, ignored slot, wrap of the scan, repeated arrivals.
    t_stim_row directed_rows [20] = '{
        '{OP_CHOOSE, 5'd0,  1, 1'b1, NONE_PICKED},
        '{OP_ARRIVE, 5'd0,  1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd31, 1, 1'b1, NONE_PICKED},
        '{OP_ARRIVE, 5'd31, 1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b1, '{5'd31, 16'd1, 1'b0, 32'd1}},
        '{OP_ARRIVE, 5'd1,  2, 1'b0, NO_WANT},
        '{OP_ARRIVE, 5'd31, 1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b1, '{5'd1, 16'd2, 1'b0, 32'd3}},
        '{OP_CHOOSE, 5'd0,  1, 1'b1, '{5'd31, 16'd1, 1'b0, 32'd4}},
        '{OP_ARRIVE, 5'd21, 1, 1'b0, NO_WANT},
        '{OP_ARRIVE, 5'd10, 1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b0, NO_WANT},
        '{OP_ARRIVE, 5'd17, REPEAT_REPS, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b1, '{5'd17, 16'd3, 1'b0, 32'd9}},
        '{OP_ARRIVE, 5'd30, 1, 1'b0, NO_WANT},
        '{OP_ARRIVE, 5'd2,  1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b0, NO_WANT},
        '{OP_CHOOSE, 5'd0,  1, 1'b1, NONE_PICKED}
    };

    // Advance the predicted state by one request; a choose yields a response.
    function automatic void apply_signal_request(input t_op op, input logic [SIGNUM_W-1:0] num,
                                                 output bit has_pick, output t_pick_result pick);
        int idx;
        bit found;
        has_pick = 1'b0;
        pick     = NONE_PICKED;
        found    = 1'b0;
        if (op == OP_ARRIVE) begin
            if (int'(num) >= FIRST_SIGNAL && int'(num) < SIGNAL_SLOTS) begin
                if (pend_cnt[num] != COUNT_MAX)
                    pend_cnt[num] = pend_cnt[num] + 1'b1;
            end
            return;
        end
        has_pick = 1'b1;
        idx = int'(scan_ptr);
        // Circular scan starting one past the pointer, wrapping to the first signal.
        for (int step = 0; step < SIGNAL_SLOTS && !found; step++) begin
            idx++;
            if (idx >= SIGNAL_SLOTS)
                idx = FIRST_SIGNAL;
            if (pend_cnt[idx] != '0) begin
                found         = 1'b1;
                handled_sum   = handled_sum + TOTAL_W'(pend_cnt[idx]);
                pick.code     = CODE_W'(idx);
                pick.count    = SIGCNT_W'(pend_cnt[idx]);
                pick.none     = 1'b0;
                pick.total    = handled_sum;
                pend_cnt[idx] = '0;
                scan_ptr      = t_slot'(idx);
            end
        end
    endfunction

    // Drive one request, with an optional idle burst ahead of it, and wait for acceptance.
    task automatic issue_request(input t_op op, input logic [SIGNUM_W-1:0] num,
                                 input bit allow_gap, input bit typed, input t_pick_result want);
        bit           has_pick;
        t_pick_result pick;
        if (allow_gap && !tail_calm && $urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.signal_number <= num;
        do @(posedge i_clk); while (!req_ch.ready);
        requests_sent++;
        apply_signal_request(op, num, has_pick, pick);
        if (has_pick)
            expected_picks.push_back(typed ? want : pick);
    endtask

    // Compare one accepted response against the oldest expectation.
    task automatic check_pick();
        t_pick_result want;
        t_pick_result got;
        got = '{rsp_ch.signal_code, rsp_ch.signal_count, rsp_ch.none_pending,
                rsp_ch.total_handled};
        if (expected_picks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected response: code %0d count %0d none %0b total %0d",
                         got.code, got.count, got.none, got.total);
            return;
        end
        want = expected_picks.pop_front();
        picks_checked++;
        if (got.none)
            empty_picks++;
        if (got.code != want.code || got.count != want.count || got.none != want.none ||
            got.total != want.total) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display({"response %0d mismatch: code %0d/%0d count %0d/%0d ",
                          "none %0b/%0b total %0d/%0d"},
                         picks_checked, got.code, want.code, got.count, want.count,
                         got.none, want.none, got.total, want.total);
        end
    endtask

    // Response side: check accepted responses and stall in random bursts.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
                check_pick();
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (tail_calm) begin
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(99) < sink_stall_pct) begin
                stall_left = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout with %0d responses outstanding", expected_picks.size());
        $display("round_robin_pending_signal_picker_test: done, errors");
        $finish;
    end

    // Reset, directed table, random phases, drain.
    initial begin
        logic [SIGNUM_W-1:0] hot [3];
        int                  choose_pct;
        bit                  focused;
        t_op                 op;
        logic [SIGNUM_W-1:0] num;
        foreach (pend_cnt[s])
            pend_cnt[s] = '0;
        scan_ptr             = '0;
        handled_sum          = '0;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_ARRIVE;
        req_ch.signal_number = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 25;
        sink_stall_pct = 30;
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++)
                issue_request(directed_rows[r].op, directed_rows[r].num, k == 0,
                              directed_rows[r].typed, directed_rows[r].want);
        end

        // Each phase picks its own mix of chooses, slot spread and idling.
        for (int phase = 0; phase < PHASES; phase++) begin
            choose_pct     = $urandom_range(15, 50);
            focused        = phase[0];
            src_idle_pct   = (phase == 2) ? 0 : 25;
            sink_stall_pct = (phase == 3) ? 0 : 30;
            tail_calm      = (phase == PHASES - 1);
            foreach (hot[h])
                hot[h] = SIGNUM_W'($urandom_range(1, 31));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < choose_pct) begin
                    op  = OP_CHOOSE;
                    num = SIGNUM_W'($urandom);
                end else begin
                    op = OP_ARRIVE;
                    if ($urandom_range(19) == 0)
                        num = '0;
                    else if (focused)
                        num = hot[$urandom_range(2)];
                    else
                        num = SIGNUM_W'($urandom_range(31));
                end
                issue_request(op, num, 1'b1, 1'b0, NO_WANT);
            end
        end
        req_ch.valid <= 1'b0;

        while (expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d requests accepted, %0d responses checked, %0d of them with nothing pending",
                 requests_sent, picks_checked, empty_picks);
        $display("covered empty picks, ignored slot zero, scan wrap and repeated arrivals");
        if (mismatch_count == 0) begin
            $display("round_robin_pending_signal_picker_test: done, clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("round_robin_pending_signal_picker_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/rrpsp_pkg.sv
sv/rrpsp_if.sv
sv/rrpsp_count_mem.sv
sv/rrpsp_pick.sv
sv/round_robin_pending_signal_picker.sv
bench/round_robin_pending_signal_picker_test.sv
